@@ hdl/led_hsv_brightness_engine_core_defines.svh @@
// Assertion macros for the LED HSV brightness engine.
// Used by led_hsv_brightness_engine_core; expects i_clk and i_rst_n in scope.
`ifndef LED_HSV_BRIGHTNESS_ENGINE_CORE_DEFINES_SVH
`define LED_HSV_BRIGHTNESS_ENGINE_CORE_DEFINES_SVH

// Check that POST holds in the same cycle as PRE.
`define LHBE_ASSERT_IMPL(NAME, PRE, POST) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (PRE) |-> (POST)) \
        else $error("lhbe assertion failed");

// Check that POST holds in the cycle after PRE.
`define LHBE_ASSERT_NEXT(NAME, PRE, POST) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (PRE) |=> (POST)) \
        else $error("lhbe assertion failed");

`endif

@@ hdl/lhbe_pkg.sv @@
// Shared types and constants of the LED HSV brightness engine.
// No dependencies; used by lhbe_div and led_hsv_brightness_engine_core.
package lhbe_pkg;

    localparam int DIV_STAGES = 8;

    // Mode codes carried in tuser; any other code breathes.
    localparam logic [1:0] OP_BREATHE  = 2'd0;
    localparam logic [1:0] OP_REDUCE   = 2'd1;
    localparam logic [1:0] OP_INCREASE = 2'd2;
    // Spare code, handled as breathe.
    localparam logic [1:0] OP_SPARE    = 2'd3;

    // Channel scale: value = floor(Y / (100 * 65535)).
    localparam logic [22:0] C_DIV   = 23'd6553500;
    localparam logic [22:0] M_RECIP = 23'(64'd35184372088832 / 64'd6553500);
    localparam logic [31:0] K_ONE   = 32'hFFFF_0000;

    typedef struct packed {
        logic [6:0]  lvl;
        logic        dir;
        logic [14:0] p;      // level * 255
        logic        dzero;  // grey input
    } t_side;

    // Estimate of floor(y / C_DIV), low by at most one.
    function automatic logic [7:0] recip_q(input logic [30:0] y);
        logic [53:0] prod;
        prod = {23'b0, y} * {31'b0, M_RECIP};
        return prod[52:45];
    endfunction

endpackage

@@ hdl/lhbe_div.sv @@
// Pipelined restoring divider, two quotient bits per stage, 16-bit quotient.
// Depends on lhbe_pkg for the stage count.
module lhbe_div (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [10:0] i_rem,   // upper dividend part, below i_div
    input  logic [10:0] i_div,
    input  logic [15:0] i_low,   // lower dividend bits, shifted in MSB first
    output logic [15:0] o_quo
);

    logic [10:0] r_rem [lhbe_pkg::DIV_STAGES];
    logic [10:0] r_div [lhbe_pkg::DIV_STAGES];
    logic [15:0] r_low [lhbe_pkg::DIV_STAGES];
    logic [15:0] r_quo [lhbe_pkg::DIV_STAGES];

    for (genvar s = 0; s < lhbe_pkg::DIV_STAGES; s++) begin : g_st
        logic [10:0] w_rem_in;
        logic [10:0] w_div_in;
        logic [15:0] w_low_in;
        logic [15:0] w_quo_in;
        logic [11:0] w_t0;
        logic [11:0] w_t1;
        logic [10:0] w_r0;
        logic [10:0] n_rem;
        logic        w_q0;
        logic        w_q1;

        if (s == 0) begin : g_head
            assign w_rem_in = i_rem;
            assign w_div_in = i_div;
            assign w_low_in = i_low;
            assign w_quo_in = 16'd0;
        end else begin : g_body
            assign w_rem_in = r_rem[s-1];
            assign w_div_in = r_div[s-1];
            assign w_low_in = r_low[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        always_comb begin
            w_t0  = {w_rem_in, w_low_in[15]};
            w_q0  = (w_t0 >= {1'b0, w_div_in});
            w_r0  = w_q0 ? 11'(w_t0 - {1'b0, w_div_in}) : w_t0[10:0];
            w_t1  = {w_r0, w_low_in[14]};
            w_q1  = (w_t1 >= {1'b0, w_div_in});
            n_rem = w_q1 ? 11'(w_t1 - {1'b0, w_div_in}) : w_t1[10:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= n_rem;
                r_div[s] <= w_div_in;
                r_low[s] <= {w_low_in[13:0], 2'b00};
                r_quo[s] <= {w_quo_in[13:0], w_q0, w_q1};
            end
        end
    end

    assign o_quo = r_quo[lhbe_pkg::DIV_STAGES-1];

endmodule

@@ hdl/led_hsv_brightness_engine_core.sv @@
// LED HSV brightness engine: RGB to hue/saturation, level update, rebuild at new level.
// Depends on lhbe_pkg, lhbe_div and led_hsv_brightness_engine_core_defines.svh.
//
// Usage:
//   Input items arrive on the s_axis group. tuser carries the mode (0 breathe,
//   1 reduce from full, 2 increase from zero, 3 breathes). tdata carries red,
//   green, blue, level, breath direction and step. Each item yields exactly one
//   result item on the m_axis group: rebuilt red, green, blue, new level and
//   new direction.
//   From acceptance to tvalid on the output an item passes one front stage,
//   eight divider stages (hue and saturation dividers in parallel, two
//   quotient bits per stage), four multiply/correct stages and the output
//   register. Throughput is one item per clock; the shared clock enable of the
//   stage chain sets it.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   s_axis tready drops; no item is lost or repeated, and bubbles in the chain
//   keep moving while the output register is empty or being taken.
//   Reset (synchronous, active low) clears the valid bit of every stage; data
//   registers are not reset. The block carries no state between items.
module led_hsv_brightness_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [30:24] level_in,
    // [31] direction_in, [39:32] step
    input  logic [39:0] i_s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [30:24] level_out,
    // [31] direction_out
    output logic [31:0] o_m_axis_tdata
);

    // Advance every stage when the output register is free or being taken.
    logic w_ce;
    assign w_ce = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    // ---------------- front stage: extremes, hue numerator, level update
    logic [7:0]         w_r, w_g, w_b, w_step, w_mx, w_mn, w_d;
    logic [6:0]         w_lvl_in;
    logic               w_dir_in;
    logic signed [11:0] w_t;
    logic [10:0]        w_d6;
    logic [23:0]        w_dsc;
    logic signed [9:0]  w_l;
    lhbe_pkg::t_side    w_side;

    always_comb begin
        w_r      = i_s_axis_tdata[7:0];
        w_g      = i_s_axis_tdata[15:8];
        w_b      = i_s_axis_tdata[23:16];
        w_lvl_in = i_s_axis_tdata[30:24];
        w_dir_in = i_s_axis_tdata[31];
        w_step   = i_s_axis_tdata[39:32];

        w_mx = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_d  = w_mx - w_mn;
        w_d6 = {1'b0, w_d, 2'b00} + {2'b0, w_d, 1'b0};
        w_dsc = {w_d, 16'd0} - {16'd0, w_d};

        // hue numerator in sixths of a turn, scaled by d
        if (w_r == w_mx) begin
            w_t = $signed({4'd0, w_g}) - $signed({4'd0, w_b});
            if (w_t < 0) w_t = w_t + $signed({1'b0, w_d6});
        end else if (w_g == w_mx) begin
            w_t = $signed({3'd0, w_d, 1'b0}) + $signed({4'd0, w_b}) - $signed({4'd0, w_r});
        end else begin
            w_t = $signed({2'd0, w_d, 2'b00}) + $signed({4'd0, w_r}) - $signed({4'd0, w_g});
        end

        w_side.dir = w_dir_in;
        w_l        = w_dir_in ? ($signed({3'd0, w_lvl_in}) - $signed({2'd0, w_step}))
                              : ($signed({3'd0, w_lvl_in}) + $signed({2'd0, w_step}));
        case (i_s_axis_tuser)
            lhbe_pkg::OP_REDUCE: begin
                w_side.lvl = (w_step > 8'd100) ? 7'd0 : 7'(8'd100 - w_step);
            end
            lhbe_pkg::OP_INCREASE: begin
                w_side.lvl = (w_step >= 8'd100) ? 7'd100 : w_step[6:0];
            end
            default: begin
                if (w_l <= 0) begin
                    w_side.lvl = 7'd1;
                    w_side.dir = 1'b0;
                end else if (w_l >= 10'sd50) begin
                    w_side.lvl = 7'd50;
                    w_side.dir = 1'b1;
                end else begin
                    w_side.lvl = w_l[6:0];
                end
            end
        endcase
        w_side.p     = {w_side.lvl, 8'd0} - {8'd0, w_side.lvl};
        w_side.dzero = (w_d == 8'd0);
    end

    logic            r_t1_valid;
    lhbe_pkg::t_side r_t1_side;
    logic [10:0]     r_t1_s_rem, r_t1_s_div, r_t1_h_rem, r_t1_h_div;
    logic [15:0]     r_t1_s_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
        end else if (w_ce) begin
            r_t1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_t1_side  <= w_side;
            r_t1_s_rem <= {3'd0, w_dsc[23:16]};
            r_t1_s_low <= w_dsc[15:0];
            r_t1_s_div <= {3'd0, w_mx};
            r_t1_h_rem <= w_t[10:0];
            r_t1_h_div <= w_d6;
        end
    end

    // ---------------- divider stages: saturation and hue
    logic [15:0] w_s_quo, w_h_quo;

    lhbe_div u_sat_div (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_rem (r_t1_s_rem),
        .i_div (r_t1_s_div),
        .i_low (r_t1_s_low),
        .o_quo (w_s_quo)
    );

    lhbe_div u_hue_div (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_rem (r_t1_h_rem),
        .i_div (r_t1_h_div),
        .i_low (16'd0),
        .o_quo (w_h_quo)
    );

    // side data and valid bits travel alongside the dividers
    logic            r_dv  [lhbe_pkg::DIV_STAGES];
    lhbe_pkg::t_side r_dly [lhbe_pkg::DIV_STAGES];

    for (genvar s = 0; s < lhbe_pkg::DIV_STAGES; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (w_ce) begin
                r_dv[s] <= (s == 0) ? r_t1_valid : r_dv[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_dly[s] <= (s == 0) ? r_t1_side : r_dly[(s == 0) ? 0 : s-1];
            end
        end
    end

    // ---------------- M1: sector, fraction, first products
    lhbe_pkg::t_side w_dside;
    logic [15:0]     w_s16, w_h16, w_f;
    logic [18:0]     w_h6;
    logic [16:0]     w_fc;

    always_comb begin
        w_dside = r_dly[lhbe_pkg::DIV_STAGES-1];
        w_s16   = w_dside.dzero ? 16'd0 : w_s_quo;
        w_h16   = w_dside.dzero ? 16'd0 : w_h_quo;
        w_h6    = {1'b0, w_h16, 2'b00} + {2'b0, w_h16, 1'b0};
        w_f     = w_h6[15:0];
        w_fc    = 17'h10000 - {1'b0, w_f};
    end

    logic            r_m1_valid;
    lhbe_pkg::t_side r_m1_side;
    logic [2:0]      r_m1_k;
    logic [30:0]     r_m1_ya;
    logic [31:0]     r_m1_eb, r_m1_ec;
    logic [32:0]     w_ec;

    assign w_ec = {17'd0, w_s16} * {16'd0, w_fc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_ce) begin
            r_m1_valid <= r_dv[lhbe_pkg::DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m1_side <= w_dside;
            r_m1_k    <= w_h6[18:16];
            r_m1_ya   <= {16'd0, w_dside.p} * {15'd0, 16'hFFFF - w_s16};
            r_m1_eb   <= {16'd0, w_s16} * {16'd0, w_f};
            r_m1_ec   <= w_ec[31:0];
        end
    end

    // ---------------- M2: split products of level by the b/c numerators
    logic [31:0] w_nb, w_nc;
    assign w_nb = lhbe_pkg::K_ONE - r_m1_eb;
    assign w_nc = lhbe_pkg::K_ONE - r_m1_ec;

    logic            r_m2_valid;
    lhbe_pkg::t_side r_m2_side;
    logic [2:0]      r_m2_k;
    logic [30:0]     r_m2_ya, r_m2_bhi, r_m2_blo, r_m2_chi, r_m2_clo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_ce) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m2_side <= r_m1_side;
            r_m2_k    <= r_m1_k;
            r_m2_ya   <= r_m1_ya;
            r_m2_bhi  <= {16'd0, r_m1_side.p} * {15'd0, w_nb[31:16]};
            r_m2_blo  <= {16'd0, r_m1_side.p} * {15'd0, w_nb[15:0]};
            r_m2_chi  <= {16'd0, r_m1_side.p} * {15'd0, w_nc[31:16]};
            r_m2_clo  <= {16'd0, r_m1_side.p} * {15'd0, w_nc[15:0]};
        end
    end

    // ---------------- M3: combine, reciprocal estimate of the quotients
    logic [30:0] w_yb, w_yc;
    logic [27:0] w_vprod;
    assign w_yb    = r_m2_bhi + {16'd0, r_m2_blo[30:16]};
    assign w_yc    = r_m2_chi + {16'd0, r_m2_clo[30:16]};
    assign w_vprod = {13'd0, r_m2_side.p} * 28'd5243;

    logic            r_m3_valid;
    lhbe_pkg::t_side r_m3_side;
    logic [2:0]      r_m3_k;
    logic [30:0]     r_m3_ya, r_m3_yb, r_m3_yc;
    logic [7:0]      r_m3_qa, r_m3_qb, r_m3_qc, r_m3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (w_ce) begin
            r_m3_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m3_side <= r_m2_side;
            r_m3_k    <= r_m2_k;
            r_m3_ya   <= r_m2_ya;
            r_m3_yb   <= w_yb;
            r_m3_yc   <= w_yc;
            r_m3_qa   <= lhbe_pkg::recip_q(r_m2_ya);
            r_m3_qb   <= lhbe_pkg::recip_q(w_yb);
            r_m3_qc   <= lhbe_pkg::recip_q(w_yc);
            r_m3_v    <= w_vprod[26:19];
        end
    end

    // ---------------- M4: correct each estimate by one where the residual allows
    logic [30:0] w_res_a, w_res_b, w_res_c;
    logic [30:0] w_c31;
    logic [30:0] w_c2;
    assign w_c31   = {8'd0, lhbe_pkg::C_DIV};
    assign w_c2    = {w_c31[29:0], 1'b0};
    assign w_res_a = r_m3_ya - 31'({8'd0, r_m3_qa} * {8'd0, lhbe_pkg::C_DIV});
    assign w_res_b = r_m3_yb - 31'({8'd0, r_m3_qb} * {8'd0, lhbe_pkg::C_DIV});
    assign w_res_c = r_m3_yc - 31'({8'd0, r_m3_qc} * {8'd0, lhbe_pkg::C_DIV});

    logic            r_m4_valid;
    lhbe_pkg::t_side r_m4_side;
    logic [2:0]      r_m4_k;
    logic [7:0]      r_m4_a, r_m4_b, r_m4_c, r_m4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4_valid <= 1'b0;
        end else if (w_ce) begin
            r_m4_valid <= r_m3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m4_side <= r_m3_side;
            r_m4_k    <= r_m3_k;
            r_m4_v    <= r_m3_v;
            r_m4_a    <= r_m3_qa + {7'd0, (w_res_a >= w_c31)};
            r_m4_b    <= r_m3_qb + {7'd0, (w_res_b >= w_c31)};
            r_m4_c    <= r_m3_qc + {7'd0, (w_res_c >= w_c31)};
        end
    end

    // ---------------- output: place channels by hue sector
    logic [7:0] w_ro, w_go, w_bo;

    always_comb begin
        case (r_m4_k)
            3'd0: begin w_ro = r_m4_v; w_go = r_m4_c; w_bo = r_m4_a; end
            3'd1: begin w_ro = r_m4_b; w_go = r_m4_v; w_bo = r_m4_a; end
            3'd2: begin w_ro = r_m4_a; w_go = r_m4_v; w_bo = r_m4_c; end
            3'd3: begin w_ro = r_m4_a; w_go = r_m4_b; w_bo = r_m4_v; end
            3'd4: begin w_ro = r_m4_c; w_go = r_m4_a; w_bo = r_m4_v; end
            default: begin w_ro = r_m4_v; w_go = r_m4_a; w_bo = r_m4_b; end
        endcase
    end

    logic        r_o_valid;
    logic [31:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_ce) begin
            r_o_valid <= r_m4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_o_data <= {r_m4_side.dir, r_m4_side.lvl, w_bo, w_go, w_ro};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // ---------------- assertions
`include "led_hsv_brightness_engine_core_defines.svh"

    `LHBE_ASSERT_IMPL(a_level_range, o_m_axis_tvalid, o_m_axis_tdata[30:24] <= 7'd100)
    `LHBE_ASSERT_IMPL(a_sector_range, r_m1_valid, r_m1_k <= 3'd5)
    `LHBE_ASSERT_IMPL(a_recip_close, r_m3_valid, (w_res_b < w_c2) && (w_res_c < w_c2))
    `LHBE_ASSERT_NEXT(a_last_advance, r_m4_valid && w_ce, o_m_axis_tvalid)

endmodule

@@ verif/lhbe_color_checker.sv @@
// Result checker for led_hsv_brightness_engine_core: predicts each rebuilt colour and level.
// Depends on lhbe_pkg for the mode codes; watches both stream channels of the block.
`timescale 1ns / 100ps

module lhbe_color_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    logic [31:0] expected_colors[$];

    function automatic logic [7:0] scale_chan(logic [6:0] lvl, logic [63:0] num,
                                              logic [63:0] den);
        logic [127:0] v;
        v = ({121'b0, lvl} * 128'd255 * {64'b0, num}) / (128'd100 * {64'b0, den});
        return v[7:0];
    endfunction

    function automatic logic [31:0] predict_color(logic [39:0] d, logic [1:0] op);
        int r, g, b, mx, mn, dl, t, lv, stp;
        logic dir;
        logic [31:0] s16, h16, k, f;
        logic [63:0] h64, one;
        logic [7:0] vc, ac, bc, cc, ro, go, bo;
        r = d[7:0]; g = d[15:8]; b = d[23:16];
        lv = d[30:24]; dir = d[31]; stp = d[39:32];
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        s16 = 0; h16 = 0;
        if (mx != 0) s16 = (dl * 65535) / mx;
        if (dl != 0) begin
            if (r == mx) begin
                t = g - b;
                if (t < 0) t += 6 * dl;
            end else if (g == mx) begin
                t = 2 * dl + b - r;
            end else begin
                t = 4 * dl + r - g;
            end
            h64 = (64'(t) * 64'd65536) / 64'(6 * dl);
            h16 = (h64 > 64'hFFFF) ? 32'hFFFF : h64[31:0];
        end
        if (op == lhbe_pkg::OP_REDUCE) begin
            lv = (stp > 100) ? 0 : 100 - stp;
        end else if (op == lhbe_pkg::OP_INCREASE) begin
            lv = (stp >= 100) ? 100 : stp;
        end else begin
            lv = dir ? lv - stp : lv + stp;
            if (lv <= 0) begin
                lv = 1; dir = 1'b0;
            end else if (lv >= 50) begin
                lv = 50; dir = 1'b1;
            end
        end
        k = (h16 * 6) >> 16;
        f = (h16 * 6) & 32'hFFFF;
        one = 64'd65535 * 64'd65536;
        vc = scale_chan(lv[6:0], 1, 1);
        ac = scale_chan(lv[6:0], 64'(65535 - s16), 65535);
        bc = scale_chan(lv[6:0], one - 64'(s16) * 64'(f), one);
        cc = scale_chan(lv[6:0], one - 64'(s16) * 64'(65536 - f), one);
        case (k)
            0: begin ro = vc; go = cc; bo = ac; end
            1: begin ro = bc; go = vc; bo = ac; end
            2: begin ro = ac; go = vc; bo = cc; end
            3: begin ro = ac; go = bc; bo = vc; end
            4: begin ro = cc; go = ac; bo = vc; end
            default: begin ro = vc; go = ac; bo = bc; end
        endcase
        return {dir, lv[6:0], bo, go, ro};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            expected_colors.push_back(predict_color(i_s_tdata, i_s_tuser));
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            o_checked++;
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected item", i_m_tdata, '0);
            end else begin
                want = expected_colors.pop_front();
                if (i_m_tdata[7:0] != want[7:0])
                    report_mismatch("red", i_m_tdata, want);
                if (i_m_tdata[15:8] != want[15:8])
                    report_mismatch("green", i_m_tdata, want);
                if (i_m_tdata[23:16] != want[23:16])
                    report_mismatch("blue", i_m_tdata, want);
                if (i_m_tdata[30:24] != want[30:24])
                    report_mismatch("level", i_m_tdata, want);
                if (i_m_tdata[31] != want[31])
                    report_mismatch("direction", i_m_tdata, want);
            end
        end
        o_pending = expected_colors.size();
    end
endmodule

@@ verif/tb_led_hsv_brightness_engine_core.sv @@
// Testbench top for led_hsv_brightness_engine_core: clock, reset, stimulus and verdict.
// Depends on lhbe_pkg, the block itself and lhbe_color_checker.
`timescale 1ns / 100ps

module tb_led_hsv_brightness_engine_core;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // red, green, blue, level, direction, step from bit 0 up
    logic [1:0]  s_tuser = lhbe_pkg::OP_BREATHE;  // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;  // red, green, blue, level, direction from bit 0 up
    int          fail_count, pending, checked;
    int          sent_items = 0;

    always #5 i_clk = ~i_clk;

    led_hsv_brightness_engine_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    lhbe_color_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // Send one item: optional gap, then hold tvalid until the handshake.
    task automatic send_item(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [6:0] lvl, logic dir,
                             logic [7:0] stp, bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {stp, dir, lvl, b, g, r};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        sent_items++;
    endtask

    // Receiver: random stalls per item, with a calm stretch in the middle.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = (sent_items > 300 && sent_items < 400) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // Generous limit on the whole run.
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [1:0] op;
        logic [7:0] stp;
        logic [6:0] lvl;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, all modes, unused op, black, grey, out-of-range level.
        send_item(lhbe_pkg::OP_BREATHE,  8'd0,   8'd0,   8'd0,   7'd0,   1'b0, 8'd0,   0);
        send_item(lhbe_pkg::OP_BREATHE,  8'd255, 8'd255, 8'd255, 7'd127, 1'b1, 8'd255, 0);
        send_item(lhbe_pkg::OP_BREATHE,  8'd255, 8'd0,   8'd0,   7'd49,  1'b0, 8'd1,   0);
        send_item(lhbe_pkg::OP_BREATHE,  8'd0,   8'd255, 8'd0,   7'd1,   1'b1, 8'd1,   0);
        send_item(lhbe_pkg::OP_BREATHE,  8'd0,   8'd0,   8'd255, 7'd20,  1'b0, 8'd5,   0);
        send_item(lhbe_pkg::OP_BREATHE,  8'd255, 8'd0,   8'd1,   7'd110, 1'b0, 8'd3,   0);
        send_item(lhbe_pkg::OP_BREATHE,  8'd120, 8'd120, 8'd120, 7'd101, 1'b1, 8'd200, 0);
        send_item(lhbe_pkg::OP_REDUCE,   8'd200, 8'd100, 8'd50,  7'd0,   1'b1, 8'd0,   0);
        send_item(lhbe_pkg::OP_REDUCE,   8'd10,  8'd200, 8'd90,  7'd0,   1'b0, 8'd100, 0);
        send_item(lhbe_pkg::OP_REDUCE,   8'd10,  8'd20,  8'd250, 7'd0,   1'b1, 8'd101, 0);
        send_item(lhbe_pkg::OP_INCREASE, 8'd255, 8'd128, 8'd0,   7'd0,   1'b1, 8'd99,  0);
        send_item(lhbe_pkg::OP_INCREASE, 8'd128, 8'd255, 8'd255, 7'd0,   1'b0, 8'd100, 0);
        send_item(lhbe_pkg::OP_INCREASE, 8'd255, 8'd0,   8'd255, 7'd0,   1'b1, 8'd255, 0);
        send_item(lhbe_pkg::OP_SPARE,    8'd77,  8'd33,  8'd200, 7'd30,  1'b0, 8'd25,  0);
        send_item(lhbe_pkg::OP_SPARE,    8'd1,   8'd0,   8'd0,   7'd45,  1'b1, 8'd45,  0);

        // Hold off until the pipeline has drained once.
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Random part: mostly in-range levels, some out of range and all modes.
        repeat (700) begin
            op  = 2'($urandom_range(0, 3));
            lvl = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
            stp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
            send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), lvl,
                      1'($urandom), stp, (sent_items < 200 || sent_items > 450));
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("covered %0d items in all modes, %0d results compared", sent_items, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
